>>> hdl/twls_pkg.sv
// Shared types and constants for the throughput-weighted link selector.
package twls_pkg;

    localparam int SPEED_W       = 16;
    localparam int HIST_W        = 32;
    localparam int LEN_W         = 16;
    localparam int MASK_W        = 4;
    localparam int ACT_W         = 2;
    localparam int CFG_IDX_W     = 4;
    localparam int IN_TDATA_W    = 24;
    localparam int OUT_TDATA_W   = 8;

    // Divider retires this many quotient bits per cycle.
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_STEPS      = HIST_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd1024;
    localparam logic [HIST_W-1:0]  HIST_LIMIT  = 32'h7FFF_FFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LINK0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LINK1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LINK2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LINK3 = 4'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_DIV,
        ST_CMP,
        ST_APPLY,
        ST_CHECK,
        ST_HALVE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic igmp_pick;
        logic next_link;
        logic pick_zero;
        logic div_start;
        logic div_step;
        logic compare;
        logic apply;
        logic halve;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic drop;
        logic igmp;
        logic link_elig;
        logic hist_zero;
        logic last_link;
        logic div_done;
        logic overflow;
        logic out_free;
    } status_t;

endpackage

>>> hdl/throughput_weighted_link_selector_top.sv
// Top level of the throughput-weighted link selector.
// Sequence: dropped and IGMP frames go from dispatch straight to the result;
//   other frames scan the eligible links, dividing each nonzero history by the
//   link speed, then update the history, rescaling all histories on overflow.
// Throughput: one frame at a time; the next input transfer is taken in the idle
//   state after the result is registered. The 32/16 divider (4 bits a cycle) sets it.
// Reset: histories clear to zero, speeds return to 1024, no result pending.
module throughput_weighted_link_selector_top #(
    parameter int NUM_LINKS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: frame_len[15:0], group_ready[16], eligible_mask[20:17],
    //        has_active[21], active_link[23:22]
    input  logic [twls_pkg::IN_TDATA_W-1:0]     s_tdata,
    // tuser: is_igmp[0]
    input  logic                                s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: sent[0], chosen_link[2:1], zero[7:3]
    output logic [twls_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // configuration writes: index 0..3 selects speed_link0..speed_link3
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [twls_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [twls_pkg::SPEED_W-1:0]        cfg_data
);
    import twls_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // Speed registers are plain flops; a write never stalls.
    assign cfg_ready = 1'b1;

    twls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath latches each frame on transfer, walks the eligible links
    // through the shared divider, then updates history and the result register.
    twls_dp #(
        .NUM_LINKS (NUM_LINKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .in_igmp   (s_tuser),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // A frame in progress blocks the input side.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready
    ) else $error("input accepted while a frame is in progress");

    // A dropped frame reports link zero.
    a_drop_link_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[2:1] == 2'd0)
    ) else $error("dropped frame with nonzero link");

    // A chosen link always exists in the group.
    a_link_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[2:1]} < 3'(NUM_LINKS))
    ) else $error("chosen link outside the group");

    // Sequencer issues at most one major command per cycle.
    a_cmd_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_start, cmd.div_step, cmd.apply, cmd.halve, cmd.emit})
    ) else $error("conflicting datapath commands");

    // A result is only registered when the output slot is free.
    a_emit_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid || m_tready)
    ) else $error("result overwritten before transfer");

endmodule

>>> hdl/twls_ctrl.sv
// Sequencer for the link selector: scans links, drives the divider and update.
module twls_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  twls_pkg::status_t sts,
    output twls_pkg::cmd_t    cmd
);
    import twls_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (sts.drop || sts.igmp)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!sts.link_elig)
                begin
                    state_next = sts.last_link ? ST_APPLY : ST_SCAN;
                end
                else if (sts.hist_zero)
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = sts.last_link ? ST_APPLY : ST_SCAN;
            end
            ST_APPLY:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = sts.overflow ? ST_HALVE : ST_FINISH;
            end
            ST_HALVE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DISPATCH:
            begin
                cmd.igmp_pick = !sts.drop && sts.igmp;
            end
            ST_SCAN:
            begin
                if (!sts.link_elig)
                begin
                    cmd.next_link = !sts.last_link;
                end
                else if (sts.hist_zero)
                begin
                    cmd.pick_zero = 1'b1;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_CMP:
            begin
                cmd.compare   = 1'b1;
                cmd.next_link = !sts.last_link;
            end
            ST_APPLY:
            begin
                cmd.apply = 1'b1;
            end
            ST_CHECK:
            begin
            end
            ST_HALVE:
            begin
                cmd.halve = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> hdl/twls_dp.sv
// Datapath: link speeds, byte histories, shared divider and result register.
module twls_dp #(
    parameter int NUM_LINKS = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [twls_pkg::IN_TDATA_W-1:0]       in_data,
    input  logic                                  in_igmp,
    input  logic                                  cfg_we,
    input  logic [twls_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [twls_pkg::SPEED_W-1:0]          cfg_data,
    input  twls_pkg::cmd_t                        cmd,
    output twls_pkg::status_t                     sts,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [twls_pkg::OUT_TDATA_W-1:0]      out_data
);
    import twls_pkg::*;

    localparam int LINK_W = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;

    // configuration and history state
    logic [SPEED_W-1:0] speed_reg [4];
    logic [HIST_W-1:0]  hist_reg  [NUM_LINKS];

    // item fields
    logic [LEN_W-1:0]     len_reg;
    logic                 igmp_reg;
    logic                 ready_reg;
    logic [NUM_LINKS-1:0] mask_reg;
    logic                 has_act_reg;
    logic [ACT_W-1:0]     act_reg;

    // scan state
    logic [LINK_W-1:0]    k_reg;
    logic [LINK_W-1:0]    pick_reg;
    logic                 pick_valid_reg;
    logic [HIST_W-1:0]    best_reg;

    // divider
    logic [SPEED_W-1:0]   div_reg;
    logic [SPEED_W-1:0]   rem_reg;
    logic [HIST_W-1:0]    dvd_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SPEED_W-1:0]   rem_next;
    logic [HIST_W-1:0]    dvd_next;

    // result register
    logic                 out_valid_reg;
    logic                 sent_reg;
    logic [ACT_W-1:0]     chosen_reg;

    logic                 igmp_found;
    logic [LINK_W-1:0]    igmp_idx;
    logic                 act_ok;
    logic [LINK_W-1:0]    low_idx;
    logic [LINK_W-1:0]    final_pick;
    logic [SPEED_W-1:0]   cur_speed;

    // four restoring steps per cycle
    always_comb
    begin
        logic [SPEED_W:0] t;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        t        = '0;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            t        = {rem_next, dvd_next[HIST_W-1]};
            dvd_next = {dvd_next[HIST_W-2:0], 1'b0};
            if (t >= {1'b0, div_reg})
            begin
                t           = t - {1'b0, div_reg};
                dvd_next[0] = 1'b1;
            end
            rem_next = t[SPEED_W-1:0];
        end
    end

    // first eligible link, cyclic from the active link
    always_comb
    begin
        logic [2:0] idx3;
        igmp_found = 1'b0;
        igmp_idx   = '0;
        idx3       = '0;
        for (int i = NUM_LINKS - 1; i >= 0; i--)
        begin
            idx3 = {1'b0, act_reg} + 3'(i);
            if (idx3 >= 3'(NUM_LINKS))
            begin
                idx3 = idx3 - 3'(NUM_LINKS);
            end
            if (mask_reg[idx3[LINK_W-1:0]])
            begin
                igmp_found = 1'b1;
                igmp_idx   = idx3[LINK_W-1:0];
            end
        end
    end

    // lowest eligible link, fallback when no quotient beat the limit
    always_comb
    begin
        low_idx = '0;
        for (int i = NUM_LINKS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                low_idx = LINK_W'(i);
            end
        end
    end

    assign act_ok     = has_act_reg && ({1'b0, act_reg} < 3'(NUM_LINKS));
    assign final_pick = pick_valid_reg ? pick_reg : low_idx;
    assign cur_speed  = speed_reg[2'(k_reg)];

    always_comb
    begin
        sts.drop      = !ready_reg || (mask_reg == '0);
        sts.igmp      = igmp_reg;
        sts.link_elig = mask_reg[k_reg];
        sts.hist_zero = (hist_reg[k_reg] == '0);
        sts.last_link = (k_reg == LINK_W'(NUM_LINKS - 1));
        sts.div_done  = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        sts.overflow  = (hist_reg[pick_reg] > HIST_LIMIT);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                speed_reg[i] <= SPEED_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPEED_LINK0: speed_reg[0] <= cfg_data;
                REG_SPEED_LINK1: speed_reg[1] <= cfg_data;
                REG_SPEED_LINK2: speed_reg[2] <= cfg_data;
                REG_SPEED_LINK3: speed_reg[3] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LINKS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (cmd.apply)
        begin
            hist_reg[final_pick] <= hist_reg[final_pick] + HIST_W'(len_reg);
        end
        else if (cmd.halve)
        begin
            for (int i = 0; i < NUM_LINKS; i++)
            begin
                hist_reg[i] <= {1'b0, hist_reg[i][HIST_W-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            sent_reg   <= pick_valid_reg;
            chosen_reg <= pick_valid_reg ? ACT_W'(pick_reg) : '0;
        end
    end

    // item capture and scan bookkeeping
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            len_reg        <= in_data[15:0];
            ready_reg      <= in_data[16];
            mask_reg       <= in_data[17 +: NUM_LINKS];
            has_act_reg    <= in_data[21];
            act_reg        <= in_data[23:22];
            igmp_reg       <= in_igmp;
            k_reg          <= '0;
            pick_valid_reg <= 1'b0;
            pick_reg       <= '0;
            best_reg       <= HIST_LIMIT;
        end
        else
        begin
            if (cmd.next_link)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (cmd.igmp_pick)
            begin
                pick_valid_reg <= act_ok && igmp_found;
                pick_reg       <= igmp_idx;
            end
            if (cmd.pick_zero)
            begin
                pick_valid_reg <= 1'b1;
                pick_reg       <= k_reg;
            end
            if (cmd.compare && (dvd_reg < best_reg))
            begin
                best_reg       <= dvd_reg;
                pick_valid_reg <= 1'b1;
                pick_reg       <= k_reg;
            end
            if (cmd.apply)
            begin
                pick_valid_reg <= 1'b1;
                pick_reg       <= final_pick;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_reg <= (cur_speed == '0) ? SPEED_W'(1) : cur_speed;
            rem_reg <= '0;
            dvd_reg <= hist_reg[k_reg];
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{(OUT_TDATA_W - 1 - ACT_W){1'b0}}, chosen_reg, sent_reg};

endmodule

>>> bench/tb_throughput_weighted_link_selector_top.sv
// Self-checking testbench for the throughput-weighted link selector.
`timescale 1ns / 1ps

module tb_throughput_weighted_link_selector_top;

    import twls_pkg::*;

    localparam int LINKS = 4;

    // An index past the last speed register. Its low bits alias link 0,
    // so a decoder that drops the upper index bits shows up at once.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd12;

    // One frame descriptor as offered on the input stream.
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic              igmp;
        logic              ready;
        logic [MASK_W-1:0] mask;
        logic              has_active;
        logic [ACT_W-1:0]  act;
    } frame_t;

    // One link decision as returned on the result stream.
    typedef struct packed {
        logic             sent;
        logic [ACT_W-1:0] link;
    } pick_t;

    // Directed row: the frame, and a typed-in decision where it is obvious.
    typedef struct packed {
        frame_t f;
        logic   fixed;
        pick_t  want;
    } row_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [SPEED_W-1:0]     cfg_data = '0;

    // Shadow of the block's state, kept in step at every accepted transfer.
    logic [HIST_W-1:0]  link_bytes [LINKS];
    logic [SPEED_W-1:0] link_weight [LINKS];

    pick_t pending_picks [$];
    int    mismatches = 0;

    // Traffic shaping knobs, set by the stimulus process.
    bit rx_fast = 1'b0;        // receiver always ready (back-to-back phase)
    bit tx_paced = 1'b1;       // sender inserts gaps between bursts
    bit hold_armed = 1'b0;     // receiver takes its one long hold-off
    int burst_left = 0;

    throughput_weighted_link_selector_top #(
        .NUM_LINKS (LINKS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run (a couple of ms).
    initial
    begin
        #60_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Link decision for one frame; updates the shadow byte counts.
    function automatic pick_t select_link(input frame_t f);
        pick_t            r;
        logic [HIST_W-1:0] best;
        logic [HIST_W-1:0] q;
        logic [HIST_W-1:0] div;
        logic [ACT_W-1:0]  idx;
        bit                stop;
        int                k;
        r    = '{sent: 1'b0, link: '0};
        stop = 1'b0;
        if (f.ready && f.mask != '0)
        begin
            if (f.igmp)
            begin
                // IGMP: first eligible link going round from the active one.
                if (f.has_active)
                begin
                    for (k = 0; k < LINKS; k++)
                    begin
                        idx = f.act + ACT_W'(k);
                        if (!r.sent && f.mask[idx])
                        begin
                            r.sent = 1'b1;
                            r.link = idx;
                        end
                    end
                end
            end
            else
            begin
                best = HIST_LIMIT;
                for (k = 0; k < LINKS; k++)
                begin
                    if (!stop && f.mask[k])
                    begin
                        if (link_bytes[k] == '0)
                        begin
                            // idle link wins outright
                            r.sent = 1'b1;
                            r.link = ACT_W'(k);
                            stop   = 1'b1;
                        end
                        else
                        begin
                            div = (link_weight[k] == '0) ? 32'd1 : HIST_W'(link_weight[k]);
                            q   = link_bytes[k] / div;
                            if (q < best)
                            begin
                                best   = q;
                                r.sent = 1'b1;
                                r.link = ACT_W'(k);
                            end
                        end
                    end
                end
                // nothing below the limit: lowest eligible link
                if (!r.sent)
                begin
                    for (k = LINKS - 1; k >= 0; k--)
                    begin
                        if (f.mask[k])
                        begin
                            r.sent = 1'b1;
                            r.link = ACT_W'(k);
                        end
                    end
                end
                link_bytes[r.link] = link_bytes[r.link] + HIST_W'(f.len);
                if (link_bytes[r.link] > HIST_LIMIT)
                begin
                    for (k = 0; k < LINKS; k++)
                        link_bytes[k] = link_bytes[k] >> 1;
                end
            end
        end
        return r;
    endfunction

    // Offer one frame and hold it until the input transfer. Valid stays
    // high afterwards; lowering it is up to the pacing or idle logic.
    task automatic send_frame(input frame_t f, input logic fixed, input pick_t want);
        pick_t got;
        s_tvalid <= 1'b1;
        s_tdata  <= {f.act, f.has_active, f.mask, f.ready, f.len};
        s_tuser  <= f.igmp;
        do
            @(posedge clk);
        while (!s_tready);
        got = select_link(f);
        pending_picks.push_back(fixed ? want : got);
    endtask

    // Bursts of random length with random gaps between them.
    task automatic pace_sender();
        if (tx_paced)
        begin
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(0, 16);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // Registers are only touched with nothing in flight.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all four speeds; optionally one write to an unmapped index.
    task automatic program_speeds(input logic [SPEED_W-1:0] w0, input logic [SPEED_W-1:0] w1,
                                  input logic [SPEED_W-1:0] w2, input logic [SPEED_W-1:0] w3,
                                  input bit stray);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [SPEED_W-1:0]   val [5];
        int                   i;
        idx = '{REG_SPEED_LINK0, REG_SPEED_LINK1, REG_SPEED_LINK2, REG_SPEED_LINK3,
                REG_UNMAPPED};
        val = '{w0, w1, w2, w3, SPEED_W'($urandom)};
        for (i = 0; i < (stray ? 5 : 4); i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            if (idx[i] <= REG_SPEED_LINK3)
                link_weight[idx[i][1:0]] = val[i];
        end
        cfg_valid <= 1'b0;
    endtask

    // Result checker: each result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        pick_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_picks.size() == 0)
            begin
                $error("unexpected result transfer, tdata %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_picks.pop_front();
                if (m_tdata[0] !== want.sent)
                begin
                    $error("sent: expected %0d, actual %0d", want.sent, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[2:1] !== want.link)
                begin
                    $error("chosen_link: expected %0d, actual %0d", want.link, m_tdata[2:1]);
                    mismatches++;
                end
            end
        end
    end

    // Receiver: stall pattern of its own, switching mode after segments of random
    // length, plus one long hold-off so the block backs up into its input.
    initial
    begin
        int seg_left;
        int seg_mode;
        int held;
        bit hold_done;
        seg_left  = 0;
        seg_mode  = 0;
        held      = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_fast)
            begin
                m_tready <= 1'b1;
            end
            else if (hold_armed && !hold_done)
            begin
                m_tready <= 1'b0;
                held++;
                if (held == 400)
                    hold_done = 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(4, 60);
                end
                seg_left--;
                case (seg_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 2) != 0);
                    2:       m_tready <= ~m_tready;
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Directed rows: len, igmp, ready, mask, has_active, act | fixed | sent, link.
    // Histories start at zero with all speeds at 1024.
    row_t directed_rows [21] = '{
        '{'{16'd100,  1'b0, 1'b0, 4'hF,    1'b1, 2'd0}, 1'b1, '{1'b0, 2'd0}}, // group down
        '{'{16'd100,  1'b0, 1'b1, 4'h0,    1'b1, 2'd1}, 1'b1, '{1'b0, 2'd0}}, // no link up
        '{'{16'd64,   1'b1, 1'b1, 4'hF,    1'b0, 2'd2}, 1'b1, '{1'b0, 2'd0}}, // IGMP, no active
        '{'{16'd64,   1'b1, 1'b1, 4'hF,    1'b1, 2'd2}, 1'b1, '{1'b1, 2'd2}}, // IGMP on active
        '{'{16'd64,   1'b1, 1'b1, 4'b0011, 1'b1, 2'd3}, 1'b1, '{1'b1, 2'd0}}, // IGMP wraps
        '{'{16'd64,   1'b1, 1'b1, 4'b1000, 1'b1, 2'd1}, 1'b1, '{1'b1, 2'd3}},
        '{'{16'd0,    1'b0, 1'b1, 4'hF,    1'b0, 2'd0}, 1'b1, '{1'b1, 2'd0}}, // zero length
        '{'{16'hFFFF, 1'b0, 1'b1, 4'hF,    1'b0, 2'd0}, 1'b1, '{1'b1, 2'd0}}, // still idle
        '{'{16'd1,    1'b0, 1'b1, 4'hF,    1'b0, 2'd0}, 1'b1, '{1'b1, 2'd1}}, // idle link 1
        '{'{16'hFFFF, 1'b0, 1'b1, 4'b0101, 1'b1, 2'd3}, 1'b1, '{1'b1, 2'd2}},
        '{'{16'd64,   1'b0, 1'b1, 4'b1000, 1'b0, 2'd0}, 1'b1, '{1'b1, 2'd3}},
        '{'{16'd100,  1'b0, 1'b1, 4'hF,    1'b0, 2'd0}, 1'b0, '{1'b0, 2'd0}}, // tie on zero q
        '{'{16'd64,   1'b1, 1'b0, 4'hF,    1'b1, 2'd0}, 1'b1, '{1'b0, 2'd0}},
        '{'{16'd64,   1'b1, 1'b1, 4'h0,    1'b1, 2'd0}, 1'b1, '{1'b0, 2'd0}},
        '{'{16'hFFFF, 1'b1, 1'b1, 4'h0,    1'b0, 2'd3}, 1'b1, '{1'b0, 2'd0}},
        '{'{16'd64,   1'b0, 1'b0, 4'h0,    1'b1, 2'd3}, 1'b1, '{1'b0, 2'd0}},
        '{'{16'hFFFF, 1'b0, 1'b1, 4'hF,    1'b1, 2'd3}, 1'b0, '{1'b0, 2'd0}},
        '{'{16'd1518, 1'b0, 1'b1, 4'b0110, 1'b1, 2'd1}, 1'b0, '{1'b0, 2'd0}},
        '{'{16'hFFFF, 1'b1, 1'b1, 4'hF,    1'b1, 2'd3}, 1'b1, '{1'b1, 2'd3}},
        '{'{16'd64,   1'b0, 1'b1, 4'hF,    1'b0, 2'd0}, 1'b0, '{1'b0, 2'd0}},
        '{'{16'hFFFF, 1'b1, 1'b1, 4'b0100, 1'b1, 2'd3}, 1'b1, '{1'b1, 2'd2}}  // long wrap
    };

    // Main stimulus.
    initial
    begin
        frame_t f;
        int     i;
        int     p;
        int     n;
        int     kind;
        int     lsel;
        for (i = 0; i < LINKS; i++)
        begin
            link_bytes[i]  = '0;
            link_weight[i] = SPEED_RESET;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset speeds, paced sender.
        for (i = 0; i < $size(directed_rows); i++)
        begin
            send_frame(directed_rows[i].f, directed_rows[i].fixed, directed_rows[i].want);
            pace_sender();
        end

        // Zero speed on link 0 divides as one; back-to-back frames with the
        // receiver always ready.
        wait_idle();
        program_speeds(16'd0, 16'd3, 16'hFFFF, SPEED_RESET, 1'b1);
        rx_fast  = 1'b1;
        tx_paced = 1'b0;
        f = '{len: 16'hFFFF, igmp: 1'b0, ready: 1'b1, mask: 4'b0001,
              has_active: 1'b0, act: 2'd0};
        send_frame(f, 1'b0, '{1'b0, 2'd0});
        f.mask = 4'hF;
        for (i = 0; i < 6; i++)
        begin
            f.len = LEN_W'($urandom);
            send_frame(f, 1'b0, '{1'b0, 2'd0});
        end
        wait_idle();
        rx_fast  = 1'b0;
        tx_paced = 1'b1;

        // Random part in four register settings.
        for (p = 0; p < 4; p++)
        begin
            wait_idle();
            case (p)
                0: program_speeds(SPEED_W'($urandom_range(1, 65535)),
                                  SPEED_W'($urandom_range(1, 65535)),
                                  SPEED_W'($urandom_range(1, 65535)),
                                  SPEED_W'($urandom_range(1, 65535)), 1'b0);
                1: program_speeds(16'd1, 16'hFFFF, 16'hFFFF, 16'd1, 1'b0);
                2: program_speeds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                default: program_speeds(SPEED_W'($urandom_range(1, 64)),
                                        SPEED_W'($urandom_range(1, 64)),
                                        SPEED_W'($urandom_range(1, 64)),
                                        SPEED_W'($urandom_range(1, 64)), 1'b0);
            endcase
            // long receiver hold-off while the sender keeps offering
            if (p == 1)
                hold_armed = 1'b1;
            for (n = 0; n < 300; n++)
            begin
                kind = $urandom_range(0, 19);
                lsel = $urandom_range(0, 9);
                f.igmp       = 1'b0;
                f.ready      = 1'b1;
                f.mask       = MASK_W'($urandom_range(1, 15));
                f.has_active = ($urandom_range(0, 4) != 0);
                f.act        = ACT_W'($urandom);
                case (lsel)
                    0:       f.len = '0;
                    1:       f.len = 16'hFFFF;
                    2, 3:    f.len = LEN_W'($urandom);
                    default: f.len = LEN_W'($urandom_range(64, 1518));
                endcase
                case (kind)
                    0: f = frame_t'($bits(frame_t)'({$urandom, $urandom})); // pure noise
                    1: f.ready = 1'b0;                        // group down
                    2: f.mask = '0;                           // nothing eligible
                    3, 4, 5, 6: f.igmp = 1'b1;                // IGMP frames
                    default: ;                                // weighted pick
                endcase
                send_frame(f, 1'b0, '{1'b0, 2'd0});
                pace_sender();
            end
        end

        // Drain and let any stray result show up.
        s_tvalid <= 1'b0;
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> throughput_weighted_link_selector_top.f
hdl/twls_pkg.sv
hdl/twls_ctrl.sv
hdl/twls_dp.sv
hdl/throughput_weighted_link_selector_top.sv
bench/tb_throughput_weighted_link_selector_top.sv
